@@ rtl/core/tpadc_pkg.sv @@
// Shared types, constants and the sine table generator for the three-phase converter model.
package tpadc_pkg;

  // default values for the top-level parameters
  localparam int ADC_BITS_DEF        = 12;
  localparam int AMPL_COUNTS_DEF     = 2047;
  localparam int MID_COUNTS_DEF      = 2048;
  localparam int START_PHASE_DEF     = 0;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // field widths
  localparam int PHASE_W = 24;
  localparam int FREQ_W  = 26;
  localparam int AMP_W   = 26;
  localparam int RAW_W   = 12;
  localparam int VOLT_W  = 32;
  localparam int GAIN_W  = 32;
  localparam int ZERO_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 136;

  // shared multiplier and datapath widths
  localparam int MUL_A_W = 29;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SINE_W  = 25;   // magnitude, up to 1.0 in Q24
  localparam int TRIG_W  = 26;   // signed sine / cosine
  localparam int AB_W    = 27;   // alpha, beta, t
  localparam int VX_W    = 28;   // phase B / C before scaling
  localparam int CNT_W   = 24;   // signed count before clamping
  localparam int Q_SHIFT   = 24;
  localparam int CNT_SHIFT = 39;  // Q24 product then round at 2^15

  localparam logic signed [MUL_B_W-1:0] SQRT3_HALF = 33'sd14529495;

  // register reset values
  localparam logic [PHASE_W-1:0] ANGLE_STEP_RST = 24'd83886;
  localparam logic [GAIN_W-1:0]  GAIN_RST       = 32'd4096;
  localparam logic [ZERO_W-1:0]  ZERO_RST       = 12'd2048;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_A     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_B     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_C     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_A     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_B     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_C     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_BC    = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_STEP, ST_ALPHA, ST_BETA, ST_CNTA, ST_T, ST_VOLTA,
    ST_CNTB, ST_CNTC, ST_VOLTB, ST_VOLTC, ST_FIN, ST_DONE
  } state_t;

  // operand pair presented to the multiplier
  typedef enum logic [3:0] {
    OP_NONE, OP_STEP, OP_ALPHA, OP_BETA, OP_CNT_A, OP_T, OP_VOLT_A,
    OP_CNT_B, OP_CNT_C, OP_VOLT_B, OP_VOLT_C
  } op_sel_t;

  // destination of the product that comes back this cycle
  typedef enum logic [3:0] {
    CAP_NONE, CAP_PHASE, CAP_ALPHA, CAP_BETA, CAP_RAW_A, CAP_T, CAP_VOLT_A,
    CAP_RAW_B, CAP_RAW_C, CAP_VOLT_B, CAP_VOLT_C
  } cap_sel_t;

  typedef struct packed {
    logic     in_ready;
    op_sel_t  op;
    cap_sel_t cap;
    logic     rom_rd;
    logic     rom_cos;
    logic     load_out;
  } ctrl_t;

  localparam logic [63:0] POLY [6] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
  };

  // quarter-wave sine magnitude, Q24, evaluated at elaboration only
  function automatic logic [SINE_W-1:0] sine_mag(input int unsigned u,
                                                 input int unsigned stb);
    logic [63:0] z, z2, p, s;
    int i;
    z  = 64'(u) << (32 - stb);
    z2 = (z * z) >> 30;
    p  = POLY[5];
    for (i = 4; i >= 0; i--) begin
      p = POLY[i] - ((p * z2) >> 30);
    end
    s = (p * z) >> 30;
    s = (s + 64'd32) >> 6;
    if (s > 64'd16777216) begin
      s = 64'd16777216;
    end
    return SINE_W'(s);
  endfunction

endpackage

@@ rtl/core/tpadc_sine.sv @@
// Quarter-wave sine lookup with quadrant folding and registered output.
module tpadc_sine import tpadc_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rd,
  input  logic                        cos_sel,
  input  logic [SINE_TABLE_BITS-1:0]  idx,
  output logic signed [TRIG_W-1:0]    val
);

  localparam int UW      = SINE_TABLE_BITS - 1;
  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam logic [SINE_TABLE_BITS-1:0] QTR_IDX = SINE_TABLE_BITS'(QUARTER);
  localparam logic [UW-1:0]              QTR_U   = UW'(QUARTER);
  localparam logic [SINE_W-1:0]          PEAK    = sine_mag(QUARTER, SINE_TABLE_BITS);

  logic [SINE_W-1:0] tab [QUARTER];

  for (genvar g = 0; g < QUARTER; g++) begin : g_tab
    assign tab[g] = sine_mag(g, SINE_TABLE_BITS);
  end

  logic [SINE_TABLE_BITS-1:0] k;
  logic [UW-1:0]              u;
  logic [SINE_W-1:0]          mag;
  logic                       neg;

  // cos(k) = sin(k + quarter turn)
  assign k = cos_sel ? idx + QTR_IDX : idx;
  always_comb begin
    if (k[SINE_TABLE_BITS-2]) begin
      u = QTR_U - {1'b0, k[SINE_TABLE_BITS-3:0]};
    end else begin
      u = {1'b0, k[SINE_TABLE_BITS-3:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      mag <= u[UW-1] ? PEAK : tab[u[UW-2:0]];
      neg <= k[SINE_TABLE_BITS-1];
    end
  end

  assign val = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

@@ rtl/core/tpadc_mul.sv @@
// Shared signed multiplier with registered product.
module tpadc_mul import tpadc_pkg::*; (
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  a,
  input  logic signed [MUL_B_W-1:0]  b,
  output logic signed [MUL_P_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

@@ rtl/core/tpadc_ctrl.sv @@
// Sequencer that schedules the shared multiplier for one sample tick.
module tpadc_ctrl import tpadc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_free,
  output ctrl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_STEP;
      ST_STEP:  state_next = ST_ALPHA;
      ST_ALPHA: state_next = ST_BETA;
      ST_BETA:  state_next = ST_CNTA;
      ST_CNTA:  state_next = ST_T;
      ST_T:     state_next = ST_VOLTA;
      ST_VOLTA: state_next = ST_CNTB;
      ST_CNTB:  state_next = ST_CNTC;
      ST_CNTC:  state_next = ST_VOLTB;
      ST_VOLTB: state_next = ST_VOLTC;
      ST_VOLTC: state_next = ST_FIN;
      ST_FIN:   state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // a product issued in one state is captured in the next
  always_comb begin
    ctl = '{in_ready: 1'b0, op: OP_NONE, cap: CAP_NONE, rom_rd: 1'b0,
            rom_cos: 1'b0, load_out: 1'b0};
    unique case (state)
      ST_IDLE:  ctl.in_ready = 1'b1;
      ST_STEP: begin
        ctl.op      = OP_STEP;
        ctl.rom_rd  = 1'b1;
        ctl.rom_cos = 1'b1;
      end
      ST_ALPHA: begin
        ctl.cap    = CAP_PHASE;
        ctl.op     = OP_ALPHA;
        ctl.rom_rd = 1'b1;
      end
      ST_BETA: begin
        ctl.cap = CAP_ALPHA;
        ctl.op  = OP_BETA;
      end
      ST_CNTA: begin
        ctl.cap = CAP_BETA;
        ctl.op  = OP_CNT_A;
      end
      ST_T: begin
        ctl.cap = CAP_RAW_A;
        ctl.op  = OP_T;
      end
      ST_VOLTA: begin
        ctl.cap = CAP_T;
        ctl.op  = OP_VOLT_A;
      end
      ST_CNTB: begin
        ctl.cap = CAP_VOLT_A;
        ctl.op  = OP_CNT_B;
      end
      ST_CNTC: begin
        ctl.cap = CAP_RAW_B;
        ctl.op  = OP_CNT_C;
      end
      ST_VOLTB: begin
        ctl.cap = CAP_RAW_C;
        ctl.op  = OP_VOLT_B;
      end
      ST_VOLTC: begin
        ctl.cap = CAP_VOLT_B;
        ctl.op  = OP_VOLT_C;
      end
      ST_FIN:   ctl.cap = CAP_VOLT_C;
      ST_DONE:  ctl.load_out = out_free;
      default:  ctl.in_ready = 1'b0;
    endcase
  end

endmodule

@@ rtl/core/three_phase_adc_signal_model.sv @@
// Top level: NCO, inverse Clarke and converter model around one shared multiplier.
//
//  channel  | group     | moves                                   | when
//  ---------+-----------+-----------------------------------------+--------------------------
//  input    | s_axis_*  | one sample tick request (freq, amp)     | tvalid & tready
//  output   | m_axis_*  | three raw counts and three volt values  | tvalid & tready
//  config   | cfg_*     | one register write                      | cfg_we
//
//  An item takes the accept step plus twelve sequencer steps with the output drained,
//  paced by the single 29x33 multiplier that forms all ten products in turn.
//  The result sits in an output register; the next request is taken while it waits.
//  If that register is still full at the end of a tick the sequencer holds until it drains.
//  Reset restores the register defaults and the start phase; there is no clearing pass.
module three_phase_adc_signal_model import tpadc_pkg::*; #(
  parameter int ADC_BITS        = ADC_BITS_DEF,
  parameter int AMPL_COUNTS     = AMPL_COUNTS_DEF,
  parameter int MID_COUNTS      = MID_COUNTS_DEF,
  parameter int START_PHASE     = START_PHASE_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // freq_scale, amp_scale
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // raw_a, raw_b, raw_c, volt_a, volt_b, volt_c
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic signed [MUL_B_W-1:0] AMPL_OP = MUL_B_W'(AMPL_COUNTS * 32768);
  localparam logic signed [MUL_P_W-1:0] CNT_RND = MUL_P_W'(64'd1 << (CNT_SHIFT - 1));
  localparam logic signed [CNT_W-1:0]   MID     = CNT_W'(MID_COUNTS);
  localparam logic signed [CNT_W-1:0]   RAW_MAX = CNT_W'((1 << ADC_BITS) - 1);

  // configuration
  logic [PHASE_W-1:0]       angle_step;
  logic signed [GAIN_W-1:0] gain_a, gain_b, gain_c;
  logic [ZERO_W-1:0]        zero_a, zero_b, zero_c;
  logic                     swap_bc;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_step <= ANGLE_STEP_RST;
      gain_a     <= GAIN_RST;
      gain_b     <= GAIN_RST;
      gain_c     <= GAIN_RST;
      zero_a     <= ZERO_RST;
      zero_b     <= ZERO_RST;
      zero_c     <= ZERO_RST;
      swap_bc    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_STEP: angle_step <= cfg_data[PHASE_W-1:0];
        REG_GAIN_A:     gain_a     <= cfg_data;
        REG_GAIN_B:     gain_b     <= cfg_data;
        REG_GAIN_C:     gain_c     <= cfg_data;
        REG_ZERO_A:     zero_a     <= cfg_data[ZERO_W-1:0];
        REG_ZERO_B:     zero_b     <= cfg_data[ZERO_W-1:0];
        REG_ZERO_C:     zero_c     <= cfg_data[ZERO_W-1:0];
        REG_SWAP_BC:    swap_bc    <= cfg_data[0];
        default:        swap_bc    <= swap_bc;
      endcase
    end
  end

  // control
  ctrl_t ctl;
  logic  in_accept;
  logic  out_free;

  assign s_axis_tready = ctl.in_ready;
  assign in_accept     = s_axis_tvalid & ctl.in_ready;
  assign out_free      = ~m_axis_tvalid | m_axis_tready;

  tpadc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // latched request and phase
  logic signed [FREQ_W-1:0]    freq_r;
  logic [AMP_W-1:0]            amp_r;
  logic [SINE_TABLE_BITS-1:0]  k_r;
  logic [PHASE_W-1:0]          phase_acc, phase_acc_next;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      freq_r <= s_axis_tdata[FREQ_W-1:0];
      amp_r  <= s_axis_tdata[FREQ_W +: AMP_W];
      k_r    <= phase_acc[PHASE_W-1 -: SINE_TABLE_BITS];
    end
  end

  logic signed [TRIG_W-1:0]   trig;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  prod;

  tpadc_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
    .clk     (clk),
    .rd      (ctl.rom_rd),
    .cos_sel (ctl.rom_cos),
    .idx     (k_r),
    .val     (trig)
  );

  tpadc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // working registers
  logic signed [AB_W-1:0]   alpha_r, beta_r, t_r;
  logic [ADC_BITS-1:0]      cnt_a, cnt_b, cnt_c;
  logic [VOLT_W-1:0]        volt_a, volt_b, volt_c;

  logic signed [AB_W-1:0]   h;
  logic signed [VX_W-1:0]   vb, vc, x_b, x_c;

  assign h  = alpha_r >>> 1;
  assign vb = VX_W'(t_r) - VX_W'(h);
  assign vc = -VX_W'(h) - VX_W'(t_r);
  assign x_b = swap_bc ? vc : vb;
  assign x_c = swap_bc ? vb : vc;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.op)
      OP_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      OP_STEP: begin
        mul_a = MUL_A_W'(freq_r);
        mul_b = MUL_B_W'($signed({1'b0, angle_step}));
      end
      OP_ALPHA, OP_BETA: begin
        mul_a = MUL_A_W'($signed({1'b0, amp_r}));
        mul_b = MUL_B_W'(trig);
      end
      OP_CNT_A: begin
        mul_a = MUL_A_W'(alpha_r);
        mul_b = AMPL_OP;
      end
      OP_T: begin
        mul_a = MUL_A_W'(beta_r);
        mul_b = SQRT3_HALF;
      end
      OP_CNT_B: begin
        mul_a = MUL_A_W'(x_b);
        mul_b = AMPL_OP;
      end
      OP_CNT_C: begin
        mul_a = MUL_A_W'(x_c);
        mul_b = AMPL_OP;
      end
      OP_VOLT_A: begin
        mul_a = $signed(MUL_A_W'(cnt_a)) - $signed(MUL_A_W'(zero_a));
        mul_b = MUL_B_W'(gain_a);
      end
      OP_VOLT_B: begin
        mul_a = $signed(MUL_A_W'(cnt_b)) - $signed(MUL_A_W'(zero_b));
        mul_b = MUL_B_W'(gain_b);
      end
      OP_VOLT_C: begin
        mul_a = $signed(MUL_A_W'(cnt_c)) - $signed(MUL_A_W'(zero_c));
        mul_b = MUL_B_W'(gain_c);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Q24 floor, then round at 2^15, both folded into one shift; then mid-scale and clamp
  logic signed [MUL_P_W-1:0] cnt_sum;
  logic signed [CNT_W-1:0]   cnt_n;
  logic [ADC_BITS-1:0]       cnt_clamp;

  always_comb begin
    cnt_sum = prod + CNT_RND;
    cnt_n   = CNT_W'(cnt_sum >>> CNT_SHIFT) + MID;
    if (cnt_n < 0) begin
      cnt_clamp = '0;
    end else if (cnt_n > RAW_MAX) begin
      cnt_clamp = RAW_MAX[ADC_BITS-1:0];
    end else begin
      cnt_clamp = cnt_n[ADC_BITS-1:0];
    end
  end

  assign phase_acc_next = phase_acc + prod[Q_SHIFT +: PHASE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= PHASE_W'(START_PHASE);
    end else if (ctl.cap == CAP_PHASE) begin
      phase_acc <= phase_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cap)
      CAP_ALPHA:  alpha_r <= prod[Q_SHIFT +: AB_W];
      CAP_BETA:   beta_r  <= prod[Q_SHIFT +: AB_W];
      CAP_T:      t_r     <= prod[Q_SHIFT +: AB_W];
      CAP_RAW_A:  cnt_a   <= cnt_clamp;
      CAP_RAW_B:  cnt_b   <= cnt_clamp;
      CAP_RAW_C:  cnt_c   <= cnt_clamp;
      CAP_VOLT_A: volt_a  <= prod[VOLT_W-1:0];
      CAP_VOLT_B: volt_b  <= prod[VOLT_W-1:0];
      CAP_VOLT_C: volt_c  <= prod[VOLT_W-1:0];
      default:    alpha_r <= alpha_r;
    endcase
  end

  // output register
  logic [OUT_DATA_W-1:0] out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_data <= {4'b0, volt_c, volt_b, volt_a,
                   RAW_W'(cnt_c), RAW_W'(cnt_b), RAW_W'(cnt_a)};
    end
  end

  assign m_axis_tdata = out_data;

endmodule

@@ rtl/core/tpadc_checker.sv @@
// Port-level checks for the three-phase converter model, bound to the top level.
module tpadc_checker import tpadc_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_DATA_W-1:0]   s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_DATA_W-1:0]  m_axis_tdata
);

  // one request at a time: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a request was taken");

  // a tick runs through the sequencer states before the output is loaded, so no result can show up the cycle after
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared one cycle after the request");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

endmodule

bind three_phase_adc_signal_model tpadc_checker u_tpadc_checker (.*);
